### rtl/core/page_frame_refcount_allocator_macros.svh
// Assertion macros for the page frame refcount allocator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PAGE_FRAME_REFCOUNT_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_REFCOUNT_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define PFRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfra assertion failed");

// next-cycle implication, disabled in reset
`define PFRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfra assertion failed");

`endif

### rtl/core/pfra_pkg.sv
// Shared types, codes and constants for the page frame refcount allocator.
// No dependencies; imported by every module of the block except pfra_ram.
`default_nettype none

package pfra_pkg;

    localparam int FUNC_W    = 2;
    localparam int FRAME_W   = 13;
    localparam int COUNT_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_NUM_FRAMES    = 8192;
    localparam int DEF_RESERVED_MARK = 100;

    localparam logic [CFG_W-1:0] RST_FREE_START = CFG_W'(2048);
    localparam logic [CFG_W-1:0] RST_FREE_END   = CFG_W'(8192);
    localparam logic [CFG_W-1:0] RST_SHARE_FLOOR = CFG_W'(256);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_SHARE = 2'd2,
        FUNC_INIT  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_OOM         = 3'd1,
        STAT_NOPAGE      = 3'd2,
        STAT_ALREADY_FREE = 3'd3,
        STAT_NOT_COUNTED = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREE_START  = 2'd0,
        CFG_FREE_END    = 2'd1,
        CFG_SHARE_FLOOR = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        UOP_ALLOC = 2'd0,
        UOP_FREE  = 2'd1,
        UOP_SHARE = 2'd2,
        UOP_SWEEP = 2'd3
    } t_unit_op;

    typedef enum logic [2:0] {
        S_CLEAR    = 3'd0,
        S_IDLE     = 3'd1,
        S_RD       = 3'd2,
        S_UPD      = 3'd3,
        S_SCAN_RD  = 3'd4,
        S_SCAN_CHK = 3'd5,
        S_SWEEP    = 3'd6,
        S_DONE     = 3'd7
    } t_state;

    typedef struct packed {
        t_unit_op           op;
        logic [COUNT_W-1:0] count;
        logic               in_range;
    } t_unit_req;

    typedef struct packed {
        logic               we;
        logic [COUNT_W-1:0] wr_data;
        logic [COUNT_W-1:0] res_count;
        t_status            status;
        logic               hit;
    } t_unit_resp;

endpackage

`default_nettype wire

### rtl/core/pfra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies; width and depth come from parameters.
`default_nettype none

module pfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/pfra_count_unit.sv
// Shared count update unit: zero test, decrement, saturating increment, sweep value.
// Depends on pfra_pkg for the request, response and status types.
`default_nettype none

module pfra_count_unit import pfra_pkg::*; #(
    parameter int RESERVED_MARK = DEF_RESERVED_MARK
) (
    input  wire t_unit_req  i_req,
    output t_unit_resp      o_resp
);

    localparam logic [COUNT_W-1:0] MARK = COUNT_W'(RESERVED_MARK);
    localparam logic [COUNT_W-1:0] ONE  = COUNT_W'(1);

    always_comb begin
        o_resp           = '0;
        o_resp.wr_data   = i_req.count;
        o_resp.res_count = i_req.count;
        o_resp.status    = STAT_OK;
        unique case (i_req.op)
            UOP_ALLOC: begin
                o_resp.hit       = (i_req.count == '0);
                o_resp.we        = (i_req.count == '0);
                o_resp.wr_data   = ONE;
                o_resp.res_count = ONE;
            end
            UOP_FREE: begin
                if (i_req.count == '0) begin
                    o_resp.status    = STAT_ALREADY_FREE;
                    o_resp.res_count = '0;
                end else begin
                    o_resp.we        = 1'b1;
                    o_resp.wr_data   = i_req.count - ONE;
                    o_resp.res_count = i_req.count - ONE;
                end
            end
            UOP_SHARE: begin
                if (!i_req.in_range) begin
                    o_resp.status = STAT_NOT_COUNTED;
                end else if (i_req.count != '1) begin
                    o_resp.we        = 1'b1;
                    o_resp.wr_data   = i_req.count + ONE;
                    o_resp.res_count = i_req.count + ONE;
                end
            end
            UOP_SWEEP: begin
                o_resp.we      = 1'b1;
                o_resp.wr_data = i_req.in_range ? '0 : MARK;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/pfra_seq.sv
// Sequencer: state machine, frame address counter, config and result registers.
// Depends on pfra_pkg and the assertion macros header.
`default_nettype none
`include "page_frame_refcount_allocator_macros.svh"

module pfra_seq import pfra_pkg::*; #(
    parameter int NUM_FRAMES = DEF_NUM_FRAMES,
    parameter int ADDR_W = $clog2(NUM_FRAMES)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [FUNC_W-1:0]    i_func,
    input  wire logic [FRAME_W-1:0]   i_page_index,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [FRAME_W-1:0]   o_frame,
    output logic      [COUNT_W-1:0]   o_ref_count,
    output logic      [STATUS_W-1:0]  o_status,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_mem_we,
    output logic      [ADDR_W-1:0]    o_mem_waddr,
    output logic      [COUNT_W-1:0]   o_mem_wdata,
    output logic      [ADDR_W-1:0]    o_mem_raddr,
    input  wire logic [COUNT_W-1:0]   i_mem_rdata,
    output t_unit_req                 o_unit_req,
    input  wire t_unit_resp           i_unit_resp
);

    localparam int CW = ((ADDR_W > CFG_W) ? ADDR_W : CFG_W) + 1;
    localparam logic [CW-1:0]     NUM_W      = CW'(NUM_FRAMES);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(NUM_FRAMES - 1);
    localparam logic [ADDR_W-1:0] FIRST_ADDR = ADDR_W'(1);

    t_state                r_state, n_state;
    t_func                 r_func, n_func;
    logic [FRAME_W-1:0]    r_page, n_page;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [FRAME_W-1:0]    r_res_frame, n_res_frame;
    logic [COUNT_W-1:0]    r_res_count, n_res_count;
    t_status               r_res_status, n_res_status;
    logic                  r_o_valid;
    logic [FRAME_W-1:0]    r_o_frame;
    logic [COUNT_W-1:0]    r_o_count;
    t_status               r_o_status;
    logic [CFG_W-1:0]      r_start, r_end, r_floor;

    logic w_accept, w_out_load, w_free_bad, w_share_bad, w_in_window, w_above_floor;
    logic [CW-1:0] w_page_cw, w_addr_cw;

    assign w_accept      = i_in_valid && o_in_ready;
    assign w_out_load    = !r_o_valid || i_out_ready;
    assign w_page_cw     = CW'(i_page_index);
    assign w_addr_cw     = CW'(r_addr);
    assign w_free_bad    = (w_page_cw >= CW'(r_end)) || (w_page_cw >= NUM_W);
    assign w_share_bad   = (w_page_cw >= NUM_W);
    assign w_in_window   = (w_addr_cw >= CW'(r_start)) && (w_addr_cw < CW'(r_end));
    assign w_above_floor = (CW'(r_page) >= CW'(r_floor));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST_ADDR) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_func'(i_func))
                        FUNC_ALLOC: n_state = S_SCAN_RD;
                        FUNC_FREE:  n_state = w_free_bad ? S_DONE : S_RD;
                        FUNC_SHARE: n_state = w_share_bad ? S_DONE : S_RD;
                        FUNC_INIT:  n_state = S_SWEEP;
                    endcase
                end
            end
            S_RD:      n_state = S_UPD;
            S_UPD:     n_state = S_DONE;
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (i_unit_resp.hit || r_addr == FIRST_ADDR) n_state = S_DONE;
                else n_state = S_SCAN_RD;
            end
            S_SWEEP: begin
                if (r_addr == LAST_ADDR) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_func              = r_func;
        n_page              = r_page;
        n_addr              = r_addr;
        n_res_frame         = r_res_frame;
        n_res_count         = r_res_count;
        n_res_status        = r_res_status;
        o_mem_we            = 1'b0;
        o_unit_req.op       = UOP_SWEEP;
        o_unit_req.count    = i_mem_rdata;
        o_unit_req.in_range = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_we = 1'b1;
                n_addr   = r_addr + FIRST_ADDR;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_func       = t_func'(i_func);
                    n_page       = i_page_index;
                    n_res_frame  = i_page_index;
                    n_res_count  = '0;
                    n_res_status = STAT_NOPAGE;
                    unique case (t_func'(i_func))
                        FUNC_ALLOC: n_addr = LAST_ADDR;
                        FUNC_FREE:  n_addr = ADDR_W'(i_page_index);
                        FUNC_SHARE: n_addr = ADDR_W'(i_page_index);
                        FUNC_INIT: begin
                            n_addr       = '0;
                            n_res_frame  = '0;
                            n_res_status = STAT_OK;
                        end
                    endcase
                end
            end
            S_UPD: begin
                o_unit_req.op       = (r_func == FUNC_FREE) ? UOP_FREE : UOP_SHARE;
                o_unit_req.in_range = w_above_floor;
                o_mem_we            = i_unit_resp.we;
                n_res_frame         = r_page;
                n_res_count         = i_unit_resp.res_count;
                n_res_status        = i_unit_resp.status;
            end
            S_SCAN_CHK: begin
                o_unit_req.op = UOP_ALLOC;
                o_mem_we      = i_unit_resp.we;
                n_addr        = r_addr - FIRST_ADDR;
                if (i_unit_resp.hit) begin
                    n_res_frame  = FRAME_W'(r_addr);
                    n_res_count  = i_unit_resp.res_count;
                    n_res_status = STAT_OK;
                end else begin
                    n_res_frame  = '0;
                    n_res_count  = '0;
                    n_res_status = STAT_OOM;
                end
            end
            S_SWEEP: begin
                o_unit_req.in_range = w_in_window;
                o_mem_we            = 1'b1;
                n_addr              = r_addr + FIRST_ADDR;
            end
            S_RD, S_SCAN_RD, S_DONE: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_o_valid <= 1'b0;
            r_start   <= RST_FREE_START;
            r_end     <= RST_FREE_END;
            r_floor   <= RST_SHARE_FLOOR;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            if (r_state == S_DONE && w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_FREE_START:  r_start <= i_cfg_data;
                    CFG_FREE_END:    r_end   <= i_cfg_data;
                    CFG_SHARE_FLOOR: r_floor <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_page       <= n_page;
        r_res_frame  <= n_res_frame;
        r_res_count  <= n_res_count;
        r_res_status <= n_res_status;
        if (r_state == S_DONE && w_out_load) begin
            r_o_frame  <= r_res_frame;
            r_o_count  <= r_res_count;
            r_o_status <= r_res_status;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_o_valid;
    assign o_frame     = r_o_frame;
    assign o_ref_count = r_o_count;
    assign o_status    = r_o_status;
    assign o_mem_waddr = r_addr;
    assign o_mem_raddr = r_addr;
    assign o_mem_wdata = i_unit_resp.wr_data;

    `PFRA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_in_ready)
    `PFRA_ASSERT_IMP(a_no_write_when_waiting, i_clk, i_rst_n, o_mem_we,
        r_state != S_IDLE && r_state != S_DONE)
    `PFRA_ASSERT_IMP(a_result_from_done, i_clk, i_rst_n, r_o_valid && !$past(r_o_valid),
        $past(r_state) == S_DONE)
    `PFRA_ASSERT_IMP(a_oom_is_empty, i_clk, i_rst_n, r_o_valid && r_o_status == STAT_OOM,
        r_o_frame == '0 && r_o_count == '0)

endmodule

`default_nettype wire

### rtl/core/page_frame_refcount_allocator.sv
// Free and share: a count read (S_RD), then an update (S_UPD); out-of-range ones skip both.
// Alloc: frames scanned from the top index down, one RAM read and check each.
// Init: one count-RAM write per cycle, over all NUM_FRAMES. One item in flight at a time.
// Reset: synchronous, active low; a clearing pass then writes zero to all NUM_FRAMES counts,
// one per cycle, with the input not ready; config writes are taken throughout.
// Depends on pfra_pkg, pfra_ram, pfra_count_unit and pfra_seq.
`default_nettype none

module page_frame_refcount_allocator import pfra_pkg::*; #(
    parameter int NUM_FRAMES    = DEF_NUM_FRAMES,
    parameter int RESERVED_MARK = DEF_RESERVED_MARK
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [FUNC_W-1:0]    i_func,
    input  wire logic [FRAME_W-1:0]   i_page_index,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [FRAME_W-1:0]   o_frame,
    output logic      [COUNT_W-1:0]   o_ref_count,
    output logic      [STATUS_W-1:0]  o_status,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int ADDR_W = $clog2(NUM_FRAMES);

    logic               w_mem_we;
    logic [ADDR_W-1:0]  w_mem_waddr;
    logic [ADDR_W-1:0]  w_mem_raddr;
    logic [COUNT_W-1:0] w_mem_wdata;
    logic [COUNT_W-1:0] w_mem_rdata;
    t_unit_req          w_unit_req;
    t_unit_resp         w_unit_resp;

    pfra_seq #(
        .NUM_FRAMES (NUM_FRAMES),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_page_index (i_page_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_frame      (o_frame),
        .o_ref_count  (o_ref_count),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata),
        .o_unit_req   (w_unit_req),
        .i_unit_resp  (w_unit_resp)
    );

    pfra_count_unit #(
        .RESERVED_MARK (RESERVED_MARK)
    ) u_count_unit (
        .i_req  (w_unit_req),
        .o_resp (w_unit_resp)
    );

    pfra_ram #(
        .WIDTH  (COUNT_W),
        .DEPTH  (NUM_FRAMES),
        .ADDR_W (ADDR_W)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for page_frame_refcount_allocator: directed and random requests
// with random backpressure, checked against an in-bench model of the frame count table.
// Depends on pfra_pkg and the allocator RTL.

module tb_top;
    import pfra_pkg::*;

    localparam int NUM_FRAMES     = DEF_NUM_FRAMES;
    localparam int RESERVED_MARK  = DEF_RESERVED_MARK;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 120000;
    localparam int DRAIN_LIMIT    = 50000;
    localparam int TAIL_CYCLES    = 20;
    localparam int SHALLOW_SCAN   = 64;
    localparam int RECENT_DEPTH   = 32;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] ref_count;
        t_status            status;
    } t_frame_result;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [FUNC_W-1:0]    req_func = '0;
    logic [FRAME_W-1:0]   req_page = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [FRAME_W-1:0]   out_frame;
    logic [COUNT_W-1:0]   out_ref_count;
    logic [STATUS_W-1:0]  out_status;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic [COUNT_W-1:0]   count_table [NUM_FRAMES];
    logic [CFG_W-1:0]     reg_free_start;
    logic [CFG_W-1:0]     reg_free_end;
    logic [CFG_W-1:0]     reg_share_floor;
    t_frame_result        frame_results_due [$];
    logic [FRAME_W-1:0]   recent_frames [$];

    bit offer_open   = 1'b0;
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;
    int errors       = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int reg_writes   = 0;
    int op_counts [4];
    int status_hits [5];
    int stall_cycles = 0;
    int deep_scans_left = 8;
    int inits_left   = 10;

    page_frame_refcount_allocator uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_func       (req_func),
        .i_page_index (req_page),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_frame      (out_frame),
        .o_ref_count  (out_ref_count),
        .o_status     (out_status),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic t_frame_result next_frame_result(input t_func f,
                                                        input logic [FRAME_W-1:0] pg);
        t_frame_result r;
        int i;
        int hi;
        bit found;
        r.frame = '0;
        r.ref_count = '0;
        r.status = STAT_OK;
        case (f)
            FUNC_ALLOC: begin
                found = 1'b0;
                r.status = STAT_OOM;
                for (i = NUM_FRAMES - 1; i > 0 && !found; i--) begin
                    if (count_table[i] == '0) begin
                        count_table[i] = COUNT_W'(1);
                        r.frame = FRAME_W'(i);
                        r.ref_count = COUNT_W'(1);
                        r.status = STAT_OK;
                        found = 1'b1;
                    end
                end
            end
            FUNC_FREE: begin
                r.frame = pg;
                if (int'(pg) >= int'(reg_free_end) || int'(pg) >= NUM_FRAMES) begin
                    r.status = STAT_NOPAGE;
                end else if (count_table[pg] == '0) begin
                    r.status = STAT_ALREADY_FREE;
                end else begin
                    count_table[pg] = count_table[pg] - 1'b1;
                    r.ref_count = count_table[pg];
                end
            end
            FUNC_SHARE: begin
                r.frame = pg;
                if (int'(pg) >= NUM_FRAMES) begin
                    r.status = STAT_NOPAGE;
                end else if (int'(pg) < int'(reg_share_floor)) begin
                    r.status = STAT_NOT_COUNTED;
                    r.ref_count = count_table[pg];
                end else begin
                    if (count_table[pg] != '1)
                        count_table[pg] = count_table[pg] + 1'b1;
                    r.ref_count = count_table[pg];
                end
            end
            default: begin
                hi = (int'(reg_free_end) > NUM_FRAMES) ? NUM_FRAMES : int'(reg_free_end);
                for (i = 0; i < NUM_FRAMES; i++)
                    count_table[i] = COUNT_W'(RESERVED_MARK);
                for (i = int'(reg_free_start); i < hi; i++)
                    count_table[i] = '0;
            end
        endcase
        return r;
    endfunction

    function automatic int free_scan_depth();
        int i;
        for (i = NUM_FRAMES - 1; i > 0; i--)
            if (count_table[i] == '0)
                return NUM_FRAMES - i;
        return NUM_FRAMES;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [FRAME_W-1:0] pick_page();
        int r;
        int lo;
        int hi;
        r = $urandom_range(0, 99);
        if (r < 40 && recent_frames.size() > 0)
            return recent_frames[$urandom_range(0, recent_frames.size() - 1)];
        if (r < 60) begin
            case ($urandom_range(0, 7))
                0: return FRAME_W'(reg_free_start);
                1: return FRAME_W'(reg_free_start - 1'b1);
                2: return FRAME_W'(reg_free_end);
                3: return FRAME_W'(reg_free_end - 1'b1);
                4: return FRAME_W'(reg_share_floor);
                5: return FRAME_W'(reg_share_floor - 1'b1);
                6: return '0;
                default: return '1;
            endcase
        end
        if (r < 80) begin
            lo = int'(reg_free_start);
            hi = (int'(reg_free_end) > NUM_FRAMES) ? NUM_FRAMES : int'(reg_free_end);
            if (hi > lo)
                return FRAME_W'($urandom_range(lo, hi - 1));
        end
        return FRAME_W'($urandom);
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        if (errors < 100)
            $display("MISMATCH at %0t: %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    task automatic close_offer();
        if (offer_open) begin
            in_valid <= 1'b0;
            offer_open = 1'b0;
        end
    endtask

    task automatic send_item(input t_func f, input logic [FRAME_W-1:0] pg);
        int gap;
        t_frame_result r;
        gap = pick_gap();
        if (offer_open && gap > 0) begin
            in_valid <= 1'b0;
            offer_open = 1'b0;
        end
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        req_func <= f;
        req_page <= pg;
        offer_open = 1'b1;
        do @(posedge clk); while (!in_ready);
        r = next_frame_result(f, pg);
        frame_results_due.push_back(r);
        requests_sent++;
        op_counts[int'(f)]++;
        if (f == FUNC_ALLOC && r.status == STAT_OK) begin
            recent_frames.push_back(r.frame);
            if (recent_frames.size() > RECENT_DEPTH)
                void'(recent_frames.pop_front());
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_FREE_START:  reg_free_start = val;
            CFG_FREE_END:    reg_free_end = val;
            CFG_SHARE_FLOOR: reg_share_floor = val;
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        close_offer();
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_item(FUNC_ALLOC, '1);
        send_item(FUNC_ALLOC, '0);
        send_item(FUNC_FREE, FRAME_W'(8191));
        send_item(FUNC_FREE, FRAME_W'(8191));
        send_item(FUNC_FREE, '0);
        send_item(FUNC_SHARE, '0);
        send_item(FUNC_SHARE, FRAME_W'(8190));
        send_item(FUNC_SHARE, FRAME_W'(256));
    endtask

    task automatic test_init_release();
        drain_results();
        write_reg(CFG_FREE_START, CFG_W'(8190));
        write_reg(CFG_SHARE_FLOOR, CFG_W'(256));
        send_item(FUNC_INIT, FRAME_W'(4321));
        send_item(FUNC_ALLOC, '0);
        send_item(FUNC_ALLOC, '0);
        send_item(FUNC_FREE, FRAME_W'(8191));
        send_item(FUNC_FREE, FRAME_W'(100));
        send_item(FUNC_SHARE, FRAME_W'(255));
        send_item(FUNC_SHARE, FRAME_W'(8189));
    endtask

    task automatic test_range_limits();
        drain_results();
        write_reg(CFG_FREE_END, CFG_W'(8000));
        write_reg(CFG_SHARE_FLOOR, CFG_W'(0));
        write_reg(CFG_UNUSED_IDX, '1);
        send_item(FUNC_FREE, FRAME_W'(8000));
        send_item(FUNC_FREE, FRAME_W'(7999));
        send_item(FUNC_SHARE, '0);
        drain_results();
        write_reg(CFG_FREE_END, CFG_W'(0));
        write_reg(CFG_SHARE_FLOOR, '1);
        send_item(FUNC_FREE, '0);
        send_item(FUNC_SHARE, '1);
    endtask

    task automatic test_out_of_memory();
        drain_results();
        write_reg(CFG_FREE_START, CFG_W'(0));
        write_reg(CFG_FREE_END, CFG_W'(1));
        send_item(FUNC_INIT, '1);
        send_item(FUNC_ALLOC, '1);
        send_item(FUNC_FREE, '0);
        drain_results();
        write_reg(CFG_FREE_START, '1);
        write_reg(CFG_FREE_END, '1);
        send_item(FUNC_FREE, FRAME_W'(1));
    endtask

    task automatic test_backpressure();
        drain_results();
        write_reg(CFG_SHARE_FLOOR, CFG_W'(0));
        quiet = 1'b1;
        hold_request = 1'b1;
        repeat (8) send_item(FUNC_SHARE, pick_page());
        drain_results();
        quiet = 1'b0;
        repeat (4) begin
            send_item(FUNC_FREE, pick_page());
            send_item(FUNC_SHARE, pick_page());
        end
    endtask

    task automatic run_traffic_phase(input logic [CFG_W-1:0] start_pg,
                                     input logic [CFG_W-1:0] end_pg,
                                     input logic [CFG_W-1:0] floor_pg,
                                     input int n, input bit hot);
        t_func f;
        logic [FRAME_W-1:0] pg;
        logic [FRAME_W-1:0] hot_page;
        int k;
        int r;
        drain_results();
        write_reg(CFG_FREE_START, start_pg);
        write_reg(CFG_FREE_END, end_pg);
        write_reg(CFG_SHARE_FLOOR, floor_pg);
        recent_frames.delete();
        send_item(FUNC_INIT, FRAME_W'($urandom));
        hot_page = FRAME_W'($urandom_range(1000, 7000));
        for (k = 0; k < n; k++) begin
            if (k % 60 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (hot) begin
                if (r < 94)
                    f = FUNC_SHARE;
                else if (r < 98)
                    f = FUNC_FREE;
                else
                    f = FUNC_ALLOC;
                pg = (r < 98) ? hot_page : FRAME_W'($urandom);
            end else begin
                if (r < 30)
                    f = FUNC_ALLOC;
                else if (r < 62)
                    f = FUNC_FREE;
                else if (r < 99)
                    f = FUNC_SHARE;
                else
                    f = FUNC_INIT;
                pg = pick_page();
            end
            if (f == FUNC_ALLOC && free_scan_depth() > SHALLOW_SCAN) begin
                if (deep_scans_left > 0)
                    deep_scans_left--;
                else
                    f = FUNC_SHARE;
            end
            if (f == FUNC_INIT) begin
                if (inits_left > 0)
                    inits_left--;
                else
                    f = FUNC_FREE;
            end
            send_item(f, pg);
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        int p;
        run_traffic_phase(RST_FREE_START, RST_FREE_END, RST_SHARE_FLOOR, 220, 1'b0);
        run_traffic_phase(CFG_W'(0), '1, CFG_W'(0), 220, 1'b0);
        run_traffic_phase(CFG_W'(8100), CFG_W'(8192), CFG_W'(8150), 220, 1'b0);
        run_traffic_phase('1, CFG_W'(0), '1, 120, 1'b0);
        run_traffic_phase(CFG_W'(7000), CFG_W'(8150), CFG_W'(7500), 220, 1'b0);
        run_traffic_phase(CFG_W'(8191), CFG_W'(8192), CFG_W'(0), 240, 1'b1);
        for (p = 0; p < 3; p++)
            run_traffic_phase(CFG_W'($urandom_range(7000, 8191)),
                              CFG_W'($urandom_range(8150, 8200)),
                              CFG_W'($urandom_range(0, 8191)), 190, 1'b0);
    endtask

    initial begin
        int n;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        t_frame_result want;
        if (rst_n && out_valid && out_ready) begin
            if (frame_results_due.size() == 0) begin
                report_mismatch("result with no request outstanding, frame", 0, out_frame);
            end else begin
                want = frame_results_due.pop_front();
                results_seen++;
                status_hits[int'(want.status)]++;
                if (out_frame !== want.frame)
                    report_mismatch("frame", want.frame, out_frame);
                if (out_ref_count !== want.ref_count)
                    report_mismatch("ref_count", want.ref_count, out_ref_count);
                if (out_status !== want.status)
                    report_mismatch("status", want.status, out_status);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        do @(posedge clk); while (stall_cycles < WATCHDOG_LIMIT);
        $display("page_frame_refcount_allocator verification failed");
        $finish;
    end

    initial begin
        int settle;
        for (int i = 0; i < NUM_FRAMES; i++)
            count_table[i] = '0;
        reg_free_start = RST_FREE_START;
        reg_free_end = RST_FREE_END;
        reg_share_floor = RST_SHARE_FLOOR;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_init_release();
        test_range_limits();
        test_out_of_memory();
        test_backpressure();
        test_random_traffic();

        close_offer();
        settle = 0;
        while (frame_results_due.size() != 0 && settle < DRAIN_LIMIT) begin
            @(posedge clk);
            settle++;
        end
        if (frame_results_due.size() != 0)
            report_mismatch("results never delivered", frame_results_due.size(), 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d alloc, %0d free, %0d share, %0d init), %0d reg writes.",
                 requests_sent, op_counts[FUNC_ALLOC], op_counts[FUNC_FREE],
                 op_counts[FUNC_SHARE], op_counts[FUNC_INIT], reg_writes);
        $display("Checked %0d results: ok %0d, oom %0d, no page %0d, already free %0d, %s %0d.",
                 results_seen, status_hits[STAT_OK], status_hits[STAT_OOM],
                 status_hits[STAT_NOPAGE], status_hits[STAT_ALREADY_FREE], "not counted",
                 status_hits[STAT_NOT_COUNTED]);
        if (errors == 0)
            $display("page_frame_refcount_allocator verification clean");
        else
            $display("page_frame_refcount_allocator verification failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/pfra_pkg.sv
rtl/core/pfra_ram.sv
rtl/core/pfra_count_unit.sv
rtl/core/pfra_seq.sv
rtl/core/page_frame_refcount_allocator.sv
tb/sv/tb_top.sv
